FILE: src/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear-probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int CAPACITY = 256;              // power of two
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int KEY_W    = 32;
  localparam int HASH_W   = 32;
  localparam int VAL_W    = 64;
  localparam int CNT_W    = 9;
  localparam int SST_W    = 2;
  localparam int META_W   = SST_W + KEY_W;

  localparam logic [CNT_W-1:0] MAX_LOAD_RST = CNT_W'(192);

  typedef enum logic [1:0] {
    OP_GET = 2'd0,
    OP_SET = 2'd1,
    OP_DEL = 2'd2,
    OP_BAD = 2'd3
  } op_t;

  typedef enum logic [SST_W-1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_TOMB  = 2'd2,
    SLOT_RSVD  = 2'd3
  } slot_st_t;

  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_MISSING = 2'd1,
    RES_FULL    = 2'd2,
    RES_RSVD    = 2'd3
  } res_t;

  typedef enum logic {
    CS_IDLE  = 1'b0,
    CS_PROBE = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic load;    // latch request, start probe at hash slot
    logic step;    // advance to next slot
    logic commit;  // apply writes and register the result
  } dp_cmd_t;

  typedef struct packed {
    logic stop;    // probe ends on the slot under inspection
  } dp_stat_t;

endpackage

FILE: src/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer: accepts a request, walks the probe, commits on the last slot.
// ----------------------------------------------------------------------------
module lpht_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lpht_pkg::dp_stat_t stat,
  output lpht_pkg::dp_cmd_t  cmd
);
  import lpht_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = CS_PROBE;
        end
      end
      CS_PROBE: begin
        busy = 1'b1;
        if (stat.stop) begin
          cmd.commit = 1'b1;
          state_nxt  = CS_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

endmodule

FILE: src/lpht_dp.sv
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: slot memories, probe index, tombstone tracking, result register.
// ----------------------------------------------------------------------------
module lpht_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpht_pkg::dp_cmd_t             cmd,
  output lpht_pkg::dp_stat_t            stat,
  input  logic                          cfg_wr_en,
  input  logic [lpht_pkg::CNT_W-1:0]    cfg_wr_data,
  input  logic [1:0]                    in_operation,
  input  logic [lpht_pkg::KEY_W-1:0]    in_key_id,
  input  logic [lpht_pkg::HASH_W-1:0]   in_key_hash,
  input  logic [lpht_pkg::VAL_W-1:0]    in_value_in,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic                          out_was_new,
  output logic [lpht_pkg::VAL_W-1:0]    out_value_out
);
  import lpht_pkg::*;

  // request registers
  op_t              op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;

  // probe state
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] tomb_r, tomb_nxt;
  logic             have_tomb_r, have_tomb_nxt;

  // table state
  logic [CAPACITY-1:0] valid_r;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [CNT_W-1:0]    max_load_r;

  // result registers
  logic             out_valid_r;
  res_t             status_r, status_nxt;
  logic             was_new_r, was_new_nxt;
  logic [VAL_W-1:0] vout_r, vout_nxt;

  // memory ports
  logic [IDX_W-1:0]  raddr;
  logic [META_W-1:0] meta_rd;
  logic [VAL_W-1:0]  val_rd;
  logic              meta_we, val_we;
  logic [IDX_W-1:0]  meta_waddr, val_waddr;
  logic [META_W-1:0] meta_wdata;

  // slot evaluation
  slot_st_t         slot_st;
  logic             is_hit, is_tomb, is_empty, is_last;
  logic             tomb_any, has_spot;
  logic [IDX_W-1:0] spot;

  // Read address runs one slot ahead of idx_r so each cycle checks one slot.
  assign raddr = cmd.load ? in_key_hash[IDX_W-1:0] : idx_r + 1'b1;

  lpht_ram #(.WIDTH(META_W), .DEPTH(CAPACITY)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (raddr),
    .rdata (meta_rd)
  );

  lpht_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_r),
    .raddr (raddr),
    .rdata (val_rd)
  );

  // never-written slots read as empty
  assign slot_st  = valid_r[idx_r] ? slot_st_t'(meta_rd[META_W-1 -: SST_W]) : SLOT_EMPTY;
  assign is_hit   = (slot_st == SLOT_USED) && (meta_rd[KEY_W-1:0] == key_r);
  assign is_tomb  = (slot_st == SLOT_TOMB);
  assign is_empty = (slot_st == SLOT_EMPTY);
  assign is_last  = &cnt_r;
  assign stat.stop = is_hit | is_empty | is_last;

  // insert target: first tombstone on the path, else the empty slot
  assign tomb_any = have_tomb_r | is_tomb;
  assign spot     = have_tomb_r ? tomb_r : idx_r;
  assign has_spot = is_empty | tomb_any;

  always_comb begin
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    tomb_nxt      = tomb_r;
    have_tomb_nxt = have_tomb_r;
    if (cmd.load) begin
      idx_nxt       = in_key_hash[IDX_W-1:0];
      cnt_nxt       = '0;
      have_tomb_nxt = 1'b0;
    end else if (cmd.step) begin
      idx_nxt = idx_r + 1'b1;
      cnt_nxt = cnt_r + 1'b1;
      if (is_tomb && !have_tomb_r) begin
        have_tomb_nxt = 1'b1;
        tomb_nxt      = idx_r;
      end
    end
  end

  always_comb begin
    status_nxt  = RES_MISSING;
    was_new_nxt = 1'b0;
    vout_nxt    = '0;
    used_nxt    = used_r;
    meta_we     = 1'b0;
    val_we      = 1'b0;
    meta_waddr  = idx_r;
    val_waddr   = idx_r;
    meta_wdata  = {SLOT_USED, key_r};
    if (cmd.commit) begin
      case (op_r)
        OP_GET: begin
          if (is_hit) begin
            status_nxt = RES_OK;
            vout_nxt   = val_rd;
          end
        end
        OP_SET: begin
          if (is_hit) begin
            val_we     = 1'b1;
            status_nxt = RES_OK;
          end else if (!has_spot) begin
            status_nxt = RES_FULL;
          end else if (!tomb_any && (used_r >= max_load_r)) begin
            status_nxt = RES_FULL;
          end else begin
            meta_we     = 1'b1;
            val_we      = 1'b1;
            meta_waddr  = spot;
            val_waddr   = spot;
            status_nxt  = RES_OK;
            was_new_nxt = 1'b1;
            if (!tomb_any) begin
              used_nxt = used_r + 1'b1;
            end
          end
        end
        OP_DEL: begin
          if (is_hit) begin
            meta_we    = 1'b1;
            meta_wdata = {SLOT_TOMB, key_r};
            status_nxt = RES_OK;
          end
        end
        default: begin
          status_nxt = RES_MISSING;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      used_r      <= '0;
      max_load_r  <= MAX_LOAD_RST;
      out_valid_r <= 1'b0;
      have_tomb_r <= 1'b0;
    end else begin
      if (meta_we) begin
        valid_r[meta_waddr] <= 1'b1;
      end
      used_r      <= used_nxt;
      out_valid_r <= cmd.commit;
      have_tomb_r <= have_tomb_nxt;
      if (cfg_wr_en) begin
        max_load_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_operation);
      key_r <= in_key_id;
      val_r <= in_value_in;
    end
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    tomb_r <= tomb_nxt;
    if (cmd.commit) begin
      status_r  <= status_nxt;
      was_new_r <= was_new_nxt;
      vout_r    <= vout_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_was_new   = was_new_r;
  assign out_value_out = vout_r;

endmodule

FILE: src/linear_probe_hash_table_top.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open-addressing key/value table with linear probing and tombstones.
// ----------------------------------------------------------------------------
//  port group | handshake            | payload
//  in_        | start / busy         | operation, key_id, key_hash, value_in
//  out_       | out_valid (1 cycle)  | status, was_new, value_out
//  cfg_       | cfg_wr_en            | cfg_wr_data (max_load_count)
//
//  A request is latched, then N slots are probed in turn, N in 1..256:
//  the slot memory gives one read per cycle. busy is high while the slots
//  are probed and out_valid pulses in the cycle after the last probe.
//  Reset is synchronous; slot valid bits clear at once, no clearing pass.
//  The result port has no back-pressure; out_valid is a single-cycle strobe.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_operation,
  input  logic [lpht_pkg::KEY_W-1:0]    in_key_id,
  input  logic [lpht_pkg::HASH_W-1:0]   in_key_hash,
  input  logic [lpht_pkg::VAL_W-1:0]    in_value_in,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic                          out_was_new,
  output logic [lpht_pkg::VAL_W-1:0]    out_value_out,
  input  logic                          cfg_wr_en,
  input  logic [lpht_pkg::CNT_W-1:0]    cfg_wr_data
);
  import lpht_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lpht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lpht_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_operation  (in_operation),
    .in_key_id     (in_key_id),
    .in_key_hash   (in_key_hash),
    .in_value_in   (in_value_in),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_was_new   (out_was_new),
    .out_value_out (out_value_out)
  );

endmodule

FILE: src/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks for the hash table top, bound onto every instance.
// ----------------------------------------------------------------------------
module lpht_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [1:0]                 out_status,
  input logic                       out_was_new,
  input logic [lpht_pkg::VAL_W-1:0] out_value_out
);
  import lpht_pkg::*;

  // an accepted request always occupies the probe engine next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  // every result follows a probe cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding probe");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != RES_OK) |-> (out_value_out == '0))
    else $error("nonzero value on a failed request");

  a_new_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_new) |-> (out_status == RES_OK))
    else $error("was_new set on a failed request");

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_was_new   (out_was_new),
  .out_value_out (out_value_out)
);
